/* rtl/core/segm_pkg.sv */
// Shared constants, types and table functions for the exposure and gain mapper.
`timescale 1ns / 1ps

package segm_pkg;

    localparam int NumStages = 4;
    localparam int StepCount = 11;
    localparam int GainW     = 14;
    localparam int StepW     = 12;
    localparam int RecipW    = 21;
    localparam int RecipShift = 20;
    localparam int LinesW    = 13;

    localparam logic [GainW-1:0]  GainSat     = 14'd8192;
    localparam logic [39:0]       TenQ24      = 40'd10 << 24;
    localparam logic [39:0]       LinesMaxQ24 = 40'h1fff << 24;
    localparam logic [LinesW-1:0] LinesMax    = 13'h1fff;
    localparam logic [30:0]       SecToLines  = 31'd1184659997;
    localparam logic [59:0]       SecRound    = 60'd1 << 39;

    typedef struct packed {
        logic [NumStages-1:0] en;
    } segm_stage_ctrl_t;

    function automatic logic [StepW-1:0] step_value(input logic [3:0] idx);
        logic [StepW-1:0] v;
        unique case (idx)
            4'd0:    v = 12'd64;
            4'd1:    v = 12'd91;
            4'd2:    v = 12'd127;
            4'd3:    v = 12'd182;
            4'd4:    v = 12'd258;
            4'd5:    v = 12'd369;
            4'd6:    v = 12'd516;
            4'd7:    v = 12'd738;
            4'd8:    v = 12'd1032;
            4'd9:    v = 12'd1491;
            default: v = 12'd2084;
        endcase
        return v;
    endfunction

    // Floor of 2^26 over each step value, so the estimate never overshoots.
    function automatic logic [RecipW-1:0] step_recip(input logic [3:0] idx);
        logic [RecipW-1:0] v;
        unique case (idx)
            4'd0:    v = 21'd1048576;
            4'd1:    v = 21'd737460;
            4'd2:    v = 21'd528416;
            4'd3:    v = 21'd368730;
            4'd4:    v = 21'd260111;
            4'd5:    v = 21'd181866;
            4'd6:    v = 21'd130055;
            4'd7:    v = 21'd90933;
            4'd8:    v = 21'd65027;
            4'd9:    v = 21'd45009;
            default: v = 21'd32201;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/sensor_exposure_gain_mapper.sv */
// Top level of the exposure request to sensor register mapper.
//
//  Channel | Direction | Contents
//  s_axis  | in        | analog gain, digital gain, exposure time
//  m_axis  | out       | analog step, residual digital gain, exposure line count
//
// Every transaction passes four register stages, one per step of the gain path:
// product, step search, reciprocal multiply, correction.
// A new transaction is taken in every cycle while the output side keeps up.
// Reset clears only the stage valid bits; data registers are not reset.
// A stage holds while it is full and the stage after it cannot take its data,
// so empty stages still fill during an output stall.
`timescale 1ns / 1ps

module sensor_exposure_gain_mapper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // analog_gain_q6, digital_gain_q6, exposure_time_q24, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // analog_step, digital_gain_whole,
                                  // digital_gain_fraction_reg, exposure_high,
                                  // exposure_low, zero pad
);

    localparam int NS = segm_pkg::NumStages;

    logic [NS-1:0]              valid_reg, valid_next;
    logic [NS:0]                rdy;
    segm_pkg::segm_stage_ctrl_t ctrl;
    logic [3:0]                 analog_step;
    logic [1:0]                 digital_gain_whole;
    logic [7:0]                 digital_gain_fraction_reg;
    logic [4:0]                 exposure_high;
    logic [7:0]                 exposure_low;

    assign rdy[NS] = m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_stage
            assign rdy[gi]     = !valid_reg[gi] || rdy[gi+1];
            assign ctrl.en[gi] = rdy[gi];
            if (gi == 0)
            begin : g_first
                assign valid_next[gi] = rdy[gi] ? s_tvalid : valid_reg[gi];
            end
            else
            begin : g_rest
                assign valid_next[gi] = rdy[gi] ? valid_reg[gi-1] : valid_reg[gi];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    segm_gain u_gain
    (
        .clk                       (clk),
        .ctrl                      (ctrl),
        .analog_gain_q6            (s_tdata[12:0]),
        .digital_gain_q6           (s_tdata[25:13]),
        .analog_step               (analog_step),
        .digital_gain_whole        (digital_gain_whole),
        .digital_gain_fraction_reg (digital_gain_fraction_reg)
    );

    segm_expo u_expo
    (
        .clk               (clk),
        .ctrl              (ctrl),
        .exposure_time_q24 (s_tdata[65:26]),
        .exposure_high     (exposure_high),
        .exposure_low      (exposure_low)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = {5'd0, exposure_low, exposure_high, digital_gain_fraction_reg,
                       digital_gain_whole, analog_step};

endmodule

/* rtl/core/segm_gain.sv */
// Four-stage gain path: total gain, analog step choice and residual digital gain.
`timescale 1ns / 1ps

module segm_gain
(
    input  logic                        clk,
    input  segm_pkg::segm_stage_ctrl_t  ctrl,
    input  logic [12:0]                 analog_gain_q6,
    input  logic [12:0]                 digital_gain_q6,
    output logic [3:0]                  analog_step,
    output logic [1:0]                  digital_gain_whole,
    output logic [7:0]                  digital_gain_fraction_reg
);

    logic [25:0]                 prod_reg;
    logic [segm_pkg::GainW-1:0]  gain2_reg, gain2_next;
    logic [3:0]                  idx2_reg, idx2_next;
    logic [segm_pkg::GainW-1:0]  gain3_reg;
    logic [3:0]                  idx3_reg;
    logic [7:0]                  qest3_reg, qest3_next;
    logic [3:0]                  idx4_reg;
    logic [7:0]                  resid4_reg, resid4_next;
    logic [19:0]                 g20;
    logic [34:0]                 est_prod;
    logic [19:0]                 x3;
    logic [19:0]                 qd3;
    logic [19:0]                 rem3;

    always_comb
    begin
        g20 = prod_reg[25:6];
        if (g20 > 20'(segm_pkg::GainSat))
        begin
            gain2_next = segm_pkg::GainSat;
        end
        else
        begin
            gain2_next = g20[segm_pkg::GainW-1:0];
        end
        idx2_next = 4'd0;
        for (int i = 1; i < segm_pkg::StepCount; i++)
        begin
            if (gain2_next >= segm_pkg::GainW'(segm_pkg::step_value(4'(i))))
            begin
                idx2_next = 4'(i);
            end
        end
    end

    always_comb
    begin
        est_prod   = 35'(gain2_reg) * 35'(segm_pkg::step_recip(idx2_reg));
        qest3_next = est_prod[segm_pkg::RecipShift+7:segm_pkg::RecipShift];
    end

    // The estimate is at most one below the true quotient.
    always_comb
    begin
        x3   = {gain3_reg, 6'd0};
        qd3  = 20'(qest3_reg) * 20'(segm_pkg::step_value(idx3_reg));
        rem3 = x3 - qd3;
        if (rem3 >= 20'(segm_pkg::step_value(idx3_reg)))
        begin
            resid4_next = qest3_reg + 8'd1;
        end
        else
        begin
            resid4_next = qest3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            prod_reg <= 26'(analog_gain_q6) * 26'(digital_gain_q6);
        end
        if (ctrl.en[1])
        begin
            gain2_reg <= gain2_next;
            idx2_reg  <= idx2_next;
        end
        if (ctrl.en[2])
        begin
            gain3_reg <= gain2_reg;
            idx3_reg  <= idx2_reg;
            qest3_reg <= qest3_next;
        end
        if (ctrl.en[3])
        begin
            idx4_reg   <= idx3_reg;
            resid4_reg <= resid4_next;
        end
    end

    assign analog_step               = idx4_reg;
    assign digital_gain_whole        = resid4_reg[7:6];
    assign digital_gain_fraction_reg = {resid4_reg[5:0], 2'b00};

endmodule

/* rtl/core/segm_expo.sv */
// Four-stage exposure path: line count from a line or seconds request.
`timescale 1ns / 1ps

module segm_expo
(
    input  logic                        clk,
    input  segm_pkg::segm_stage_ctrl_t  ctrl,
    input  logic [39:0]                 exposure_time_q24,
    output logic [4:0]                  exposure_high,
    output logic [7:0]                  exposure_low
);

    logic                         is_lines1_reg;
    logic [segm_pkg::LinesW-1:0]  clamp1_reg, clamp1_next;
    logic [58:0]                  prod1_reg;
    logic [segm_pkg::LinesW-1:0]  lines2_reg, lines2_next;
    logic [segm_pkg::LinesW-1:0]  lines3_reg;
    logic [segm_pkg::LinesW-1:0]  lines4_reg;
    logic [59:0]                  rounded;

    always_comb
    begin
        if (exposure_time_q24 > segm_pkg::LinesMaxQ24)
        begin
            clamp1_next = segm_pkg::LinesMax;
        end
        else
        begin
            clamp1_next = exposure_time_q24[36:24];
        end
    end

    always_comb
    begin
        rounded = 60'(prod1_reg) + segm_pkg::SecRound;
        if (is_lines1_reg)
        begin
            lines2_next = clamp1_reg;
        end
        else
        begin
            lines2_next = rounded[52:40];
        end
    end

    // Seconds requests are at most 10.0 and fit in 28 bits.
    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            is_lines1_reg <= exposure_time_q24 > segm_pkg::TenQ24;
            clamp1_reg    <= clamp1_next;
            prod1_reg     <= 59'(exposure_time_q24[27:0]) * 59'(segm_pkg::SecToLines);
        end
        if (ctrl.en[1])
        begin
            lines2_reg <= lines2_next;
        end
        if (ctrl.en[2])
        begin
            lines3_reg <= lines2_reg;
        end
        if (ctrl.en[3])
        begin
            lines4_reg <= lines3_reg;
        end
    end

    assign exposure_high = lines4_reg[12:8];
    assign exposure_low  = lines4_reg[7:0];

endmodule

/* dv/tb_sensor_exposure_gain_mapper.sv */
// Self-checking stream testbench for the exposure request to sensor register mapper.
`timescale 1ns / 1ps

module tb_sensor_exposure_gain_mapper;

    localparam int          RandomItems   = 1400;
    localparam int          StallLimit    = 2000;
    localparam int          DrainCycles   = 12;
    localparam int          GainSatValue  = 8192;
    localparam logic [39:0] TenSecondsQ24 = 40'd10 << 24;
    localparam logic [39:0] MaxLinesQ24   = 40'h1fff << 24;
    localparam logic [71:0] LineRateNum   = 72'd1184659997;
    localparam logic [71:0] LineRateHalf  = 72'd1 << 39;
    localparam int unsigned GAIN_STEPS [11] = '{64, 91, 127, 182, 258, 369, 516, 738,
                                               1032, 1491, 2084};

    typedef struct packed {
        logic [3:0] analog_step;
        logic [1:0] digital_gain_whole;
        logic [7:0] digital_gain_fraction_reg;
        logic [4:0] exposure_high;
        logic [7:0] exposure_low;
    } sensor_regs_t;

    typedef struct {
        logic [12:0]  analog_gain_q6;
        logic [12:0]  digital_gain_q6;
        logic [39:0]  exposure_time_q24;
        bit           typed;
        sensor_regs_t regs;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    sensor_regs_t pending_regs [$];
    request_row_t directed_rows [$];
    bit           no_idle = 1'b0;
    int           mismatches = 0;
    int           requests_sent = 0;
    int           results_checked = 0;
    int           quiet_cycles = 0;

    sensor_exposure_gain_mapper dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sensor_regs_t map_exposure_request(input logic [12:0] analog_q6,
                                                         input logic [12:0] digital_q6,
                                                         input logic [39:0] time_q24);
        logic [25:0]  product;
        int unsigned  gain;
        int unsigned  step;
        int unsigned  residual;
        logic [71:0]  scaled;
        logic [12:0]  lines;
        sensor_regs_t regs;
        product = 26'(analog_q6) * 26'(digital_q6);
        gain = 32'(product >> 6);
        if (gain > GainSatValue)
            gain = GainSatValue;
        step = 0;
        for (int i = 1; i < 11; i++)
        begin
            if (gain >= GAIN_STEPS[i])
                step = i;
        end
        residual = (gain * 64) / GAIN_STEPS[step];
        if (time_q24 > TenSecondsQ24)
        begin
            if (time_q24 > MaxLinesQ24)
                lines = 13'h1fff;
            else
                lines = time_q24[36:24];
        end
        else
        begin
            scaled = {32'd0, time_q24};
            scaled = (scaled * LineRateNum + LineRateHalf) >> 40;
            lines = scaled[12:0];
        end
        regs.analog_step               = step[3:0];
        regs.digital_gain_whole        = residual[7:6];
        regs.digital_gain_fraction_reg = {residual[5:0], 2'b00};
        regs.exposure_high             = lines[12:8];
        regs.exposure_low              = lines[7:0];
        return regs;
    endfunction

    function automatic void add_row(input logic [12:0] analog_q6, input logic [12:0] digital_q6,
                                    input logic [39:0] time_q24, input bit typed,
                                    input sensor_regs_t regs);
        request_row_t row;
        row.analog_gain_q6    = analog_q6;
        row.digital_gain_q6   = digital_q6;
        row.exposure_time_q24 = time_q24;
        row.typed             = typed;
        row.regs              = regs;
        directed_rows.push_back(row);
    endfunction

    task automatic send_request(input logic [12:0] analog_q6, input logic [12:0] digital_q6,
                                input logic [39:0] time_q24, input bit typed,
                                input sensor_regs_t regs);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, time_q24, digital_q6, analog_q6};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_regs.push_back(typed ? regs : map_exposure_request(analog_q6, digital_q6,
                                                                   time_q24));
        requests_sent++;
    endtask

    initial
    begin
        forever
        begin
            int gap;
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sensor_regs_t got;
            sensor_regs_t want;
            got.analog_step               = m_tdata[3:0];
            got.digital_gain_whole        = m_tdata[5:4];
            got.digital_gain_fraction_reg = m_tdata[13:6];
            got.exposure_high             = m_tdata[18:14];
            got.exposure_low              = m_tdata[26:19];
            if (pending_regs.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_regs.pop_front();
                results_checked++;
                if (got.analog_step !== want.analog_step)
                begin
                    $display("%0t: analog_step expected %0d actual %0d", $time,
                             want.analog_step, got.analog_step);
                    mismatches++;
                end
                if (got.digital_gain_whole !== want.digital_gain_whole)
                begin
                    $display("%0t: digital_gain_whole expected %0d actual %0d", $time,
                             want.digital_gain_whole, got.digital_gain_whole);
                    mismatches++;
                end
                if (got.digital_gain_fraction_reg !== want.digital_gain_fraction_reg)
                begin
                    $display("%0t: digital_gain_fraction_reg expected %0d actual %0d", $time,
                             want.digital_gain_fraction_reg, got.digital_gain_fraction_reg);
                    mismatches++;
                end
                if (got.exposure_high !== want.exposure_high)
                begin
                    $display("%0t: exposure_high expected %0d actual %0d", $time,
                             want.exposure_high, got.exposure_high);
                    mismatches++;
                end
                if (got.exposure_low !== want.exposure_low)
                begin
                    $display("%0t: exposure_low expected %0d actual %0d", $time,
                             want.exposure_low, got.exposure_low);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: no transaction for %0d cycles", $time, StallLimit);
            $display("tb_sensor_exposure_gain_mapper failed");
            $finish;
        end
    end

    initial
    begin
        sensor_regs_t none;
        logic [12:0]  ag;
        logic [12:0]  dg;
        logic [39:0]  t;
        int           kind;
        none = '0;

        add_row(13'd0, 13'd0, 40'd0, 1'b1, '0);
        add_row(13'd8191, 13'd8191, 40'hff_ffff_ffff, 1'b1, '{4'd10, 2'd3, 8'd236, 5'd31, 8'd255});
        add_row(13'd64, 13'd64, TenSecondsQ24 + 40'd1, 1'b1, '{4'd0, 2'd1, 8'd0, 5'd0, 8'd10});
        add_row(13'd1, 13'd1, TenSecondsQ24, 1'b0, none);
        add_row(13'd63, 13'd64, 40'd1, 1'b0, none);
        add_row(13'd4096, 13'd128, MaxLinesQ24, 1'b0, none);
        add_row(13'd4096, 13'd129, MaxLinesQ24 + 40'd1, 1'b0, none);
        add_row(13'd0, 13'd8191, 40'd11 << 24, 1'b0, none);
        add_row(13'd8191, 13'd0, TenSecondsQ24 - 40'd1, 1'b0, none);
        for (int i = 1; i < 11; i++)
        begin
            add_row(13'(GAIN_STEPS[i]), 13'd64, 40'd1 << (i + 20), 1'b0, none);
            if (i % 3 == 0)
                add_row(13'(GAIN_STEPS[i] - 1), 13'd64, 40'd123456 * 40'(i), 1'b0, none);
        end
        add_row(13'h1555, 13'h0aaa, 40'h55_5555_5555, 1'b0, none);
        add_row(13'h0aaa, 13'h1555, 40'haa_aaaa_aaaa, 1'b0, none);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].analog_gain_q6, directed_rows[i].digital_gain_q6,
                         directed_rows[i].exposure_time_q24, directed_rows[i].typed,
                         directed_rows[i].regs);

        for (int n = 0; n < RandomItems; n++)
        begin
            no_idle = (n % 350) < 60;
            kind = $urandom_range(0, 3);
            case (kind)
                0:
                begin
                    ag = 13'($urandom());
                    dg = 13'($urandom());
                end
                1:
                begin
                    ag = 13'($urandom_range(0, 255));
                    dg = 13'($urandom_range(0, 255));
                end
                2:
                begin
                    ag = 13'($urandom());
                    dg = 13'($urandom_range(56, 72));
                end
                default:
                begin
                    ag = 13'($urandom());
                    dg = 13'($urandom_range(0, 31));
                end
            endcase
            kind = $urandom_range(0, 3);
            case (kind)
                0:
                    t = 40'($urandom_range(0, 32'd167772160));
                1:
                begin
                    t[39:24] = 16'($urandom_range(10, 8191));
                    t[23:0]  = 24'($urandom());
                end
                2:
                begin
                    t[39:32] = 8'($urandom());
                    t[31:0]  = $urandom();
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 1)
                        t = TenSecondsQ24 + 40'($urandom_range(0, 4)) - 40'd2;
                    else
                        t = MaxLinesQ24 + 40'($urandom_range(0, 4)) - 40'd2;
                end
            endcase
            send_request(ag, dg, t, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (pending_regs.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d exposure requests (%0d directed), checked %0d register results.",
                 requests_sent, directed_rows.size(), results_checked);
        $display("Field mismatches: %0d.", mismatches);
        if (mismatches == 0)
            $display("tb_sensor_exposure_gain_mapper passed");
        else
            $display("tb_sensor_exposure_gain_mapper failed");
        $finish;
    end

endmodule
